@@ sv/caff_ciff_stream_validator_top_macros.svh @@
// Assertion macros for the CAFF/CIFF stream validator.
`ifndef CAFF_CIFF_STREAM_VALIDATOR_TOP_MACROS_SVH
`define CAFF_CIFF_STREAM_VALIDATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CCV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define CCV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ccv_pkg.sv @@
// Shared types, codes and helper functions of the CAFF/CIFF stream validator.
`timescale 1ns / 1ps
`default_nettype none
package ccv_pkg;

  typedef enum logic [1:0] {
    EV_PIXEL  = 2'd0,
    EV_START  = 2'd1,
    EV_ACCEPT = 2'd2,
    EV_ERROR  = 2'd3
  } event_e;

  typedef enum logic [3:0] {
    ERR_BAD_TYPE     = 4'd0,
    ERR_FIRST_NOT_HDR = 4'd1,
    ERR_HDR_SIZE     = 4'd2,
    ERR_CAFF_MAGIC   = 4'd3,
    ERR_LEN_MISMATCH = 4'd4,
    ERR_SECOND_HDR   = 4'd5,
    ERR_CRED_OVERRUN = 4'd6,
    ERR_ANI_SHORT    = 4'd7,
    ERR_CIFF_MAGIC   = 4'd8,
    ERR_SIZE_MISMATCH = 4'd9,
    ERR_NOT_MUL3     = 4'd10,
    ERR_TEXT_OVERRUN = 4'd11,
    ERR_PIXEL_COUNT  = 4'd12,
    ERR_TRUNCATED    = 4'd13
  } err_e;

  // One result beat
  typedef struct packed {
    event_e      ev;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [63:0] dur;
    logic [63:0] width;
    logic [63:0] height;
    err_e        code;
    logic        last;
  } result_t;

  // Results caused by one input byte
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } res_pair_t;

  localparam logic [7:0] CaffMagic [4] = '{8'h43, 8'h41, 8'h46, 8'h46};
  localparam logic [7:0] CiffMagic [4] = '{8'h43, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0] NewLine  = 8'h0A;
  localparam logic [7:0] NulChar  = 8'h00;
  localparam logic [63:0] HdrBlockLen  = 64'd20;
  localparam logic [63:0] CredMinLen   = 64'd14;
  localparam logic [63:0] AniMinLen    = 64'd44;
  localparam logic [63:0] ImgFixedLen  = 64'd36;
  localparam logic [63:0] ImgMinHdr    = 64'd37;

  // Residue add mod 3 (a <= 2, d <= 3)
  function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] d);
    logic [2:0] t;
    t = {1'b0, a} + {1'b0, d};
    if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

  // Byte residue mod 3: base-4 digits all weigh 1 mod 3
  function automatic logic [1:0] mod3_byte(input logic [7:0] x);
    logic [1:0] r;
    r = 2'd0;
    for (int i = 0; i < 4; i++) begin
      r = add_mod3(r, x[2*i +: 2]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/caff_ciff_stream_validator_top.sv @@
// Top level of the CAFF/CIFF stream validator.
// Input channel: one file byte per beat on data_byte_i, end_of_file_i high
// on the last byte; in_valid_i / in_stall_o handshake.
// Output channel: one event per beat (pixel, image start, file accepted,
// error with error_code_o); last_result_o marks the last event of a byte.
// Results of a byte are registered, shown the cycle after it is accepted.
// Throughput: one byte per cycle while out_stall_i is low and each byte
// gives at most one event; a byte with two events (an event plus the
// end-of-file report) holds the input while the second event drains
// from the two-entry result register.
// Stall: while the receiver stalls, the pending event holds and the input
// stalls once the result register cannot take another byte's results.
// Reset: the parser waits for a block type byte with no header seen and
// the result register is empty. After an error the block emits nothing
// until the end-of-file byte, then rearms as after reset.
`timescale 1ns / 1ps
`default_nettype none
module caff_ciff_stream_validator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_file_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       event_res_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [63:0]      frame_duration_o,
  output logic [63:0]      frame_width_o,
  output logic [63:0]      frame_height_o,
  output logic [3:0]       error_code_o,
  output logic             last_result_o
);
  import ccv_pkg::*;

  logic      accept;
  res_pair_t pair;
  result_t   head;

  assign accept = in_valid_i && !in_stall_o;

  ccv_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .data_i   (data_byte_i),
    .eof_i    (end_of_file_i),
    .res_o    (pair)
  );

  ccv_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .pair_i      (pair),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .head_o      (head),
    .in_stall_o  (in_stall_o)
  );

  // result fields
  assign event_res_o      = head.ev;
  assign red_o            = head.red;
  assign green_o          = head.green;
  assign blue_o           = head.blue;
  assign frame_duration_o = head.dur;
  assign frame_width_o    = head.width;
  assign frame_height_o   = head.height;
  assign error_code_o     = head.code;
  assign last_result_o    = head.last;

`include "caff_ciff_stream_validator_top_macros.svh"

  // an empty result register never holds off the input
  `CCV_ASSERT_NOW(a_no_idle_stall, !out_valid_o, !in_stall_o, "input stalled while idle")
  // file accepted is always the last event of its byte
  `CCV_ASSERT_NOW(a_accept_last, out_valid_o && event_res_o == EV_ACCEPT, last_result_o,
                  "accept event not last")
  // error code only on error events
  `CCV_ASSERT_NOW(a_code_zero, out_valid_o && event_res_o != EV_ERROR, error_code_o == 4'd0,
                  "error code on non-error event")

endmodule
`default_nettype wire

@@ sv/ccv_parser.sv @@
// Byte-wise TLV parser and checker: state registers plus per-byte next-state logic.
`timescale 1ns / 1ps
`default_nettype none
module ccv_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       data_i,
  input  wire logic             eof_i,
  output ccv_pkg::res_pair_t    res_o
);
  import ccv_pkg::*;

  typedef enum logic [4:0] {
    P_TYPE, P_LEN_HDR, P_LEN_CRED, P_LEN_ANI,
    P_HDR_MAGIC, P_HDR_LEN, P_HDR_COUNT,
    P_CRED_DATE, P_CRED_CLEN, P_CRED_SKIP,
    P_ANI_DUR, P_ANI_MAGIC, P_ANI_HS, P_ANI_CS, P_ANI_W, P_ANI_H,
    P_CAPTION, P_TAGS, P_PIXELS, P_QUIET
  } phase_e;

  phase_e       phase_q, phase_d;
  logic [3:0]   fbc_q, fbc_d;
  logic [63:0]  fval_q, fval_d;
  logic [63:0]  brem_q, brem_d;
  logic         hdr_seen_q, hdr_seen_d;
  logic         err_q, err_d;
  logic [63:0]  hs_q, hs_d;
  logic [63:0]  cs_q, cs_d;
  logic [63:0]  w_q, w_d;
  logic [65:0]  w3_q, w3_d;
  logic [129:0] acc_q, acc_d;
  logic [1:0]   r3_q, r3_d;
  logic [63:0]  hbl_q, hbl_d;
  logic [63:0]  dur_q, dur_d;
  logic [15:0]  pp_q, pp_d;

  // Next-state and result logic for one byte
  always_comb begin
    logic [63:0]  v_full;
    logic [63:0]  brem_dec;
    logic [63:0]  hbl_dec;
    logic         fail_en;
    err_e         fail_code;
    logic         emit_en;
    result_t      emit_r;
    result_t      eof_r;
    logic         eof_en;
    logic [64:0]  target;
    logic [64:0]  hs_cs;
    logic [1:0]   r_cs;
    logic [73:0]  prod;
    logic [129:0] acc_sum;
    logic         done8;

    phase_d    = phase_q;
    fbc_d      = fbc_q;
    fval_d     = fval_q;
    brem_d     = brem_q;
    hdr_seen_d = hdr_seen_q;
    err_d      = err_q;
    hs_d       = hs_q;
    cs_d       = cs_q;
    w_d        = w_q;
    w3_d       = w3_q;
    acc_d      = acc_q;
    r3_d       = r3_q;
    hbl_d      = hbl_q;
    dur_d      = dur_q;
    pp_d       = pp_q;

    v_full    = fval_q | ({56'd0, data_i} << {fbc_q[2:0], 3'b000});
    brem_dec  = brem_q - 64'd1;
    hbl_dec   = hbl_q - 64'd1;
    done8     = (fbc_q == 4'd7);
    fail_en   = 1'b0;
    fail_code = ERR_BAD_TYPE;
    emit_en   = 1'b0;
    emit_r    = '0;
    eof_r     = '0;
    eof_en    = 1'b0;
    target    = {1'b0, brem_dec} + 65'd20;
    hs_cs     = {1'b0, hs_q} + {1'b0, v_full};
    r_cs      = add_mod3((fbc_q == 4'd0) ? 2'd0 : r3_q, mod3_byte(data_i));
    prod      = {8'd0, w3_q} * {66'd0, data_i};
    acc_sum   = acc_q + ({56'd0, prod} << {fbc_q[2:0], 3'b000});

    // generic field gather; completing arms clear it below
    if (done8) begin
      fval_d = '0;
      fbc_d  = '0;
    end else begin
      fval_d = v_full;
      fbc_d  = fbc_q + 4'd1;
    end

    if (!err_q) begin
      case (phase_q)
        P_TYPE: begin
          fbc_d  = '0;
          fval_d = '0;
          if (data_i < 8'd1 || data_i > 8'd3) begin
            fail_en = 1'b1; fail_code = ERR_BAD_TYPE;
          end else if (data_i == 8'd1) begin
            if (hdr_seen_q) begin
              fail_en = 1'b1; fail_code = ERR_SECOND_HDR;
            end else begin
              hdr_seen_d = 1'b1;
              phase_d    = P_LEN_HDR;
            end
          end else if (!hdr_seen_q) begin
            fail_en = 1'b1; fail_code = ERR_FIRST_NOT_HDR;
          end else begin
            phase_d = (data_i == 8'd2) ? P_LEN_CRED : P_LEN_ANI;
          end
        end
        P_LEN_HDR, P_LEN_CRED, P_LEN_ANI: begin
          if (done8) begin
            brem_d = v_full;
            if (phase_q == P_LEN_HDR) begin
              if (v_full != HdrBlockLen) begin
                fail_en = 1'b1; fail_code = ERR_HDR_SIZE;
              end else phase_d = P_HDR_MAGIC;
            end else if (phase_q == P_LEN_CRED) begin
              if (v_full < CredMinLen) begin
                fail_en = 1'b1; fail_code = ERR_CRED_OVERRUN;
              end else phase_d = P_CRED_DATE;
            end else begin
              if (v_full < AniMinLen) begin
                fail_en = 1'b1; fail_code = ERR_ANI_SHORT;
              end else phase_d = P_ANI_DUR;
            end
          end
        end
        P_QUIET: begin
          fbc_d  = fbc_q;
          fval_d = fval_q;
        end
        default: begin
          // value bytes of a block
          brem_d = brem_dec;
          case (phase_q)
            P_HDR_MAGIC: begin
              fval_d = fval_q;
              if (data_i != CaffMagic[fbc_q[1:0]]) begin
                fail_en = 1'b1; fail_code = ERR_CAFF_MAGIC;
                fbc_d = fbc_q;
              end else if (fbc_q == 4'd3) begin
                fbc_d = '0; phase_d = P_HDR_LEN;
              end
            end
            P_HDR_LEN: begin
              if (done8) begin
                if (v_full != HdrBlockLen) begin
                  fail_en = 1'b1; fail_code = ERR_LEN_MISMATCH;
                end else phase_d = P_HDR_COUNT;
              end
            end
            P_HDR_COUNT: begin
            end
            P_CRED_DATE: begin
              if (fbc_q == 4'd5) begin
                fval_d = '0; fbc_d = '0; phase_d = P_CRED_CLEN;
              end
            end
            P_CRED_CLEN: begin
              if (done8) begin
                if (v_full > brem_dec) begin
                  fail_en = 1'b1; fail_code = ERR_CRED_OVERRUN;
                end else phase_d = P_CRED_SKIP;
              end
            end
            P_CRED_SKIP: begin
              fbc_d  = fbc_q;
              fval_d = fval_q;
            end
            P_ANI_DUR: begin
              if (done8) begin
                dur_d = v_full; phase_d = P_ANI_MAGIC;
              end
            end
            P_ANI_MAGIC: begin
              fval_d = fval_q;
              if (data_i != CiffMagic[fbc_q[1:0]]) begin
                fail_en = 1'b1; fail_code = ERR_CIFF_MAGIC;
                fbc_d = fbc_q;
              end else if (fbc_q == 4'd3) begin
                fbc_d = '0; phase_d = P_ANI_HS;
              end
            end
            P_ANI_HS: begin
              if (done8) begin
                hs_d = v_full; phase_d = P_ANI_CS;
              end
            end
            P_ANI_CS: begin
              r3_d = r_cs;
              if (done8) begin
                cs_d = v_full;
                if (hs_cs != target) begin
                  fail_en = 1'b1; fail_code = ERR_SIZE_MISMATCH;
                end else if (r_cs != 2'd0) begin
                  fail_en = 1'b1; fail_code = ERR_NOT_MUL3;
                end else if (hs_q < ImgMinHdr) begin
                  fail_en = 1'b1; fail_code = ERR_TEXT_OVERRUN;
                end else phase_d = P_ANI_W;
              end
            end
            P_ANI_W: begin
              if (done8) begin
                w_d     = v_full;
                w3_d    = {2'b00, v_full} + {1'b0, v_full, 1'b0};
                acc_d   = '0;
                phase_d = P_ANI_H;
              end
            end
            P_ANI_H: begin
              // running 3*w*h against content size, no wrap
              acc_d = acc_sum;
              if (done8) begin
                if (acc_sum != {66'd0, cs_q}) begin
                  fail_en = 1'b1; fail_code = ERR_PIXEL_COUNT;
                end else begin
                  emit_en       = 1'b1;
                  emit_r.ev     = EV_START;
                  emit_r.dur    = dur_q;
                  emit_r.width  = w_q;
                  emit_r.height = v_full;
                  hbl_d         = hs_q - ImgFixedLen;
                  phase_d       = P_CAPTION;
                end
              end
            end
            P_CAPTION: begin
              fbc_d  = fbc_q;
              fval_d = fval_q;
              hbl_d  = hbl_dec;
              if (data_i == NewLine) begin
                phase_d = (hbl_dec == 64'd0) ? P_PIXELS : P_TAGS;
              end else if (hbl_dec == 64'd0) begin
                fail_en = 1'b1; fail_code = ERR_TEXT_OVERRUN;
              end
            end
            P_TAGS: begin
              fbc_d  = fbc_q;
              fval_d = fval_q;
              hbl_d  = hbl_dec;
              if (hbl_dec == 64'd0) begin
                if (data_i == NulChar) phase_d = P_PIXELS;
                else begin
                  fail_en = 1'b1; fail_code = ERR_TEXT_OVERRUN;
                end
              end
            end
            P_PIXELS: begin
              fval_d = fval_q;
              if (fbc_q == 4'd0) begin
                pp_d  = {8'd0, data_i};
                fbc_d = 4'd1;
              end else if (fbc_q == 4'd1) begin
                pp_d  = {data_i, pp_q[7:0]};
                fbc_d = 4'd2;
              end else begin
                emit_en      = 1'b1;
                emit_r.ev    = EV_PIXEL;
                emit_r.red   = pp_q[7:0];
                emit_r.green = pp_q[15:8];
                emit_r.blue  = data_i;
                fbc_d        = 4'd0;
              end
            end
            default: begin
              fbc_d  = fbc_q;
              fval_d = fval_q;
            end
          endcase
          // block boundary
          if (!fail_en && brem_dec == 64'd0) begin
            phase_d = P_TYPE;
            fbc_d   = '0;
            fval_d  = '0;
          end
        end
      endcase
    end else begin
      fbc_d  = fbc_q;
      fval_d = fval_q;
    end

    if (fail_en) begin
      emit_en     = 1'b1;
      emit_r      = '0;
      emit_r.ev   = EV_ERROR;
      emit_r.code = fail_code;
      err_d       = 1'b1;
      phase_d     = P_QUIET;
    end

    // end of file: report unless in error, then rearm
    if (eof_i) begin
      if (!err_d) begin
        eof_en = 1'b1;
        if (phase_d == P_TYPE && hdr_seen_d) eof_r.ev = EV_ACCEPT;
        else begin
          eof_r.ev   = EV_ERROR;
          eof_r.code = ERR_TRUNCATED;
        end
      end
      phase_d    = P_TYPE;
      fbc_d      = '0;
      fval_d     = '0;
      brem_d     = '0;
      hdr_seen_d = 1'b0;
      err_d      = 1'b0;
      hs_d       = '0;
      cs_d       = '0;
      w_d        = '0;
      hbl_d      = '0;
      dur_d      = '0;
      pp_d       = '0;
    end

    // pack results, flag the final one
    res_o = '0;
    if (emit_en) begin
      res_o.r0      = emit_r;
      res_o.r0.last = !eof_en;
      res_o.r1      = eof_r;
      res_o.r1.last = 1'b1;
      res_o.cnt     = eof_en ? 2'd2 : 2'd1;
    end else if (eof_en) begin
      res_o.r0      = eof_r;
      res_o.r0.last = 1'b1;
      res_o.cnt     = 2'd1;
    end
  end

  // State registers, updated on accepted beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= P_TYPE;
      fbc_q      <= '0;
      fval_q     <= '0;
      brem_q     <= '0;
      hdr_seen_q <= 1'b0;
      err_q      <= 1'b0;
      hs_q       <= '0;
      cs_q       <= '0;
      w_q        <= '0;
      w3_q       <= '0;
      acc_q      <= '0;
      r3_q       <= '0;
      hbl_q      <= '0;
      dur_q      <= '0;
      pp_q       <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      fbc_q      <= fbc_d;
      fval_q     <= fval_d;
      brem_q     <= brem_d;
      hdr_seen_q <= hdr_seen_d;
      err_q      <= err_d;
      hs_q       <= hs_d;
      cs_q       <= cs_d;
      w_q        <= w_d;
      w3_q       <= w3_d;
      acc_q      <= acc_d;
      r3_q       <= r3_d;
      hbl_q      <= hbl_d;
      dur_q      <= dur_d;
      pp_q       <= pp_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/ccv_outq.sv @@
// Two-entry result register: holds the results of one byte and drains them in order.
`timescale 1ns / 1ps
`default_nettype none
module ccv_outq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ccv_pkg::res_pair_t pair_i,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output ccv_pkg::result_t       head_o,
  output logic                   in_stall_o
);
  import ccv_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  result_t    e0_q, e0_d;
  result_t    e1_q, e1_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign head_o      = e0_q;
  assign pop         = out_valid_o && !out_stall_i;
  // take a byte only if the queue is empty after this cycle's pop
  assign in_stall_o  = (cnt_q == 2'd2) || ((cnt_q == 2'd1) && out_stall_i);

  // next entries
  always_comb begin
    cnt_d = cnt_q;
    e0_d  = e0_q;
    e1_d  = e1_q;
    if (push_i) begin
      cnt_d = pair_i.cnt;
      e0_d  = pair_i.r0;
      e1_d  = pair_i.r1;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      e0_d  = e1_q;
    end
  end

  // count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

endmodule
`default_nettype wire
